// ===== sv/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// shared types and constants of the first-fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int HEADER_BYTES   = 8;
	localparam int HEAP_MAX_BYTES = 65536;
	localparam int STORE_DEPTH    = HEAP_MAX_BYTES / HEADER_BYTES;
	localparam int SLOT_W         = $clog2(STORE_DEPTH);
	localparam int VAL_W          = 17;
	localparam int NEED_W         = 18;
	localparam int STEP_W         = $clog2(STORE_DEPTH) + 1;
	localparam int ALIGN_W        = 13;
	localparam int HEAP_W         = 17;
	localparam int OFF_W          = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 17;

	// request types
	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_INIT  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP  = 2'd1;

	// datapath micro-ops
	localparam logic [3:0] OP_NONE      = 4'd0;
	localparam logic [3:0] OP_LOAD      = 4'd1;
	localparam logic [3:0] OP_CLEAR     = 4'd2;
	localparam logic [3:0] OP_RD_HEAD   = 4'd3;
	localparam logic [3:0] OP_A_CUR     = 4'd4;
	localparam logic [3:0] OP_A_ADV     = 4'd5;
	localparam logic [3:0] OP_A_EXACT   = 4'd6;
	localparam logic [3:0] OP_A_SPLIT1  = 4'd7;
	localparam logic [3:0] OP_A_SPLIT2  = 4'd8;
	localparam logic [3:0] OP_F_STEP    = 4'd9;
	localparam logic [3:0] OP_F_R1      = 4'd10;
	localparam logic [3:0] OP_F_R2      = 4'd11;
	localparam logic [3:0] OP_F_W1      = 4'd12;
	localparam logic [3:0] OP_F_R3      = 4'd13;
	localparam logic [3:0] OP_F_W2      = 4'd14;

	typedef struct packed {
		logic [3:0] op;
		logic       out_load;
		logic       res_ok;
	} ffha_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       free_ok;
		logic       cur_zero;
		logic       fits;
		logic       exact;
		logic       f_stop;
		logic       step_last;
		logic       clr_last;
	} ffha_stat_t;

	function automatic logic [SLOT_W-1:0] slot(input logic [VAL_W-1:0] off);
		return off[SLOT_W+2:3];
	endfunction

endpackage

// ===== sv/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// sequencer: walks each request through its datapath steps
// ----------------------------------------------------------------------------
module ffha_ctrl
	import ffha_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  ffha_stat_t stat,
	output ffha_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DISP    = 4'd1;
	localparam logic [3:0] S_CLEAR   = 4'd2;
	localparam logic [3:0] S_RCLR    = 4'd3;
	localparam logic [3:0] S_A_START = 4'd4;
	localparam logic [3:0] S_A_CUR   = 4'd5;
	localparam logic [3:0] S_A_CHK   = 4'd6;
	localparam logic [3:0] S_A_SPLIT = 4'd7;
	localparam logic [3:0] S_F_START = 4'd8;
	localparam logic [3:0] S_F_STEP  = 4'd9;
	localparam logic [3:0] S_F_R1    = 4'd10;
	localparam logic [3:0] S_F_R2    = 4'd11;
	localparam logic [3:0] S_F_W1    = 4'd12;
	localparam logic [3:0] S_F_R3    = 4'd13;
	localparam logic [3:0] S_F_W2    = 4'd14;
	localparam logic [3:0] S_DONE    = 4'd15;

	logic [3:0] state_q, state_d;
	logic       ok_q, ok_d;
	logic       out_valid_q;

	always_comb begin
		state_d      = state_q;
		ok_d         = ok_q;
		cmd.op       = OP_NONE;
		cmd.out_load = 1'b0;
		cmd.res_ok   = ok_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.req_type)
					REQ_ALLOC: state_d = S_A_START;
					REQ_FREE: begin
						if (stat.free_ok) begin
							state_d = S_F_START;
						end else begin
							ok_d    = 1'b0;
							state_d = S_DONE;
						end
					end
					REQ_INIT: state_d = S_CLEAR;
					default: begin
						ok_d    = 1'b0;
						state_d = S_DONE;
					end
				endcase
			end
			S_CLEAR, S_RCLR: begin
				cmd.op = OP_CLEAR;
				if (stat.clr_last) begin
					ok_d    = 1'b1;
					state_d = (state_q == S_RCLR) ? S_IDLE : S_DONE;
				end
			end
			S_A_START: begin
				cmd.op  = OP_RD_HEAD;
				state_d = S_A_CUR;
			end
			S_A_CUR: begin
				cmd.op = OP_A_CUR;
				if (stat.cur_zero) begin
					ok_d    = 1'b0;
					state_d = S_DONE;
				end else begin
					state_d = S_A_CHK;
				end
			end
			S_A_CHK: begin
				if (stat.fits && stat.exact) begin
					cmd.op  = OP_A_EXACT;
					ok_d    = 1'b1;
					state_d = S_DONE;
				end else if (stat.fits) begin
					cmd.op  = OP_A_SPLIT1;
					state_d = S_A_SPLIT;
				end else if (stat.step_last) begin
					ok_d    = 1'b0;
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_A_ADV;
					state_d = S_A_CUR;
				end
			end
			S_A_SPLIT: begin
				cmd.op  = OP_A_SPLIT2;
				ok_d    = 1'b1;
				state_d = S_DONE;
			end
			S_F_START: begin
				cmd.op  = OP_RD_HEAD;
				state_d = S_F_STEP;
			end
			S_F_STEP: begin
				cmd.op = OP_F_STEP;
				if (stat.f_stop || stat.step_last) begin
					state_d = S_F_R1;
				end
			end
			S_F_R1: begin
				cmd.op  = OP_F_R1;
				state_d = S_F_R2;
			end
			S_F_R2: begin
				cmd.op  = OP_F_R2;
				state_d = S_F_W1;
			end
			S_F_W1: begin
				cmd.op  = OP_F_W1;
				state_d = S_F_R3;
			end
			S_F_R3: begin
				cmd.op  = OP_F_R3;
				state_d = S_F_W2;
			end
			S_F_W2: begin
				cmd.op  = OP_F_W2;
				ok_d    = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RCLR;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== sv/ffha_dp.sv =====
// ----------------------------------------------------------------------------
// ffha_dp
// header stores, walk registers, request rounding and result register
// ----------------------------------------------------------------------------
module ffha_dp
	import ffha_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [1:0]            req_type,
	input  logic [OFF_W-1:0]      alloc_size,
	input  logic [OFF_W-1:0]      free_offset,
	input  ffha_cmd_t             cmd,
	output ffha_stat_t            stat,
	output logic [OFF_W-1:0]      block_offset,
	output logic                  granted
);

	logic [VAL_W-1:0]  link_mem [STORE_DEPTH];
	logic [VAL_W-1:0]  size_mem [STORE_DEPTH];
	logic [VAL_W-1:0]  link_rd_q, size_rd_q;

	logic [ALIGN_W-1:0] align_q;
	logic [HEAP_W-1:0]  heap_bytes_q;
	logic [HEAP_W-1:0]  heap_len_q;
	logic [SLOT_W-1:0]  clr_idx_q;

	logic [1:0]        type_q;
	logic              free_ok_q;
	logic [NEED_W-1:0] need_q;
	logic [VAL_W-1:0]  hdr_q, prev_q, cur_q, nxt_q;
	logic [VAL_W-1:0]  sz_hdr_q, lnk_nxt_q, hdr_link_q, hdr_size_q;
	logic [STEP_W-1:0] steps_q;

	// rounding of the allocate size
	logic [3:0]         msb;
	logic [ALIGN_W-1:0] gran;
	logic [NEED_W-1:0]  need_d;
	// free offset check
	logic [OFF_W-1:0]   hdr16;
	logic               free_ok_d;
	// heap size at init
	logic [HEAP_W-1:0]  hcap, hlen_d;

	logic [VAL_W-1:0]   rest;
	logic               merge_next, merge_prev;

	logic               link_we, size_we, link_re, size_re;
	logic [SLOT_W-1:0]  link_wa, size_wa, link_ra, size_ra;
	logic [VAL_W-1:0]   link_wd, size_wd;

	always_comb begin
		msb = 4'd3;
		for (int i = 4; i < ALIGN_W; i++) begin
			if (align_q[i]) begin
				msb = 4'(i);
			end
		end
		gran   = ALIGN_W'(1) << msb;
		need_d = (NEED_W'(gran) + NEED_W'(alloc_size) + NEED_W'(7))
			& ~(NEED_W'(gran) - NEED_W'(1));
	end

	always_comb begin
		hdr16     = free_offset - OFF_W'(HEADER_BYTES);
		free_ok_d = (free_offset != '0) && (free_offset[2:0] == 3'd0)
			&& (hdr16 >= OFF_W'(HEADER_BYTES))
			&& (HEAP_W'(hdr16) < heap_len_q);
		hcap   = (heap_bytes_q > HEAP_W'(HEAP_MAX_BYTES)) ? HEAP_W'(HEAP_MAX_BYTES)
			: heap_bytes_q;
		hlen_d = {hcap[HEAP_W-1:3], 3'd0};
		if (hlen_d < HEAP_W'(2 * HEADER_BYTES)) begin
			hlen_d = HEAP_W'(2 * HEADER_BYTES);
		end
	end

	assign rest       = VAL_W'(NEED_W'(cur_q) + need_q);
	assign merge_next = (nxt_q != '0)
		&& ((NEED_W'(hdr_q) + NEED_W'(sz_hdr_q)) == NEED_W'(nxt_q));
	assign merge_prev = (NEED_W'(prev_q) + NEED_W'(size_rd_q)) == NEED_W'(hdr_q);

	// store port selection
	always_comb begin
		link_we = 1'b0;
		size_we = 1'b0;
		link_re = 1'b0;
		size_re = 1'b0;
		link_wa = '0;
		size_wa = '0;
		link_ra = '0;
		size_ra = '0;
		link_wd = '0;
		size_wd = '0;
		case (cmd.op)
			OP_CLEAR: begin
				link_we = 1'b1;
				size_we = 1'b1;
				link_wa = clr_idx_q;
				size_wa = clr_idx_q;
				link_wd = (clr_idx_q == SLOT_W'(0)) ? VAL_W'(HEADER_BYTES) : '0;
				size_wd = (clr_idx_q == SLOT_W'(1))
					? VAL_W'(heap_len_q - HEAP_W'(HEADER_BYTES)) : '0;
			end
			OP_RD_HEAD: begin
				link_re = 1'b1;
				link_ra = slot(prev_q);
			end
			OP_A_CUR: begin
				link_re = 1'b1;
				size_re = 1'b1;
				link_ra = slot(link_rd_q);
				size_ra = slot(link_rd_q);
			end
			OP_A_EXACT: begin
				link_we = 1'b1;
				link_wa = slot(prev_q);
				link_wd = link_rd_q;
			end
			OP_A_SPLIT1: begin
				link_we = 1'b1;
				size_we = 1'b1;
				link_wa = slot(rest);
				size_wa = slot(rest);
				link_wd = link_rd_q;
				size_wd = size_rd_q - VAL_W'(need_q);
			end
			OP_A_SPLIT2: begin
				link_we = 1'b1;
				size_we = 1'b1;
				link_wa = slot(prev_q);
				size_wa = slot(cur_q);
				link_wd = rest;
				size_wd = VAL_W'(need_q);
			end
			OP_F_STEP: begin
				link_re = !stat.f_stop;
				link_ra = slot(link_rd_q);
			end
			OP_F_R1: begin
				link_re = 1'b1;
				size_re = 1'b1;
				link_ra = slot(nxt_q);
				size_ra = slot(hdr_q);
			end
			OP_F_R2: begin
				size_re = 1'b1;
				size_ra = slot(nxt_q);
			end
			OP_F_W1: begin
				link_we = 1'b1;
				size_we = 1'b1;
				link_wa = slot(hdr_q);
				size_wa = slot(hdr_q);
				link_wd = merge_next ? lnk_nxt_q : nxt_q;
				size_wd = merge_next ? (sz_hdr_q + size_rd_q) : sz_hdr_q;
			end
			OP_F_R3: begin
				size_re = 1'b1;
				size_ra = slot(prev_q);
			end
			OP_F_W2: begin
				link_we = 1'b1;
				size_we = 1'b1;
				link_wa = slot(prev_q);
				size_wa = slot(prev_q);
				link_wd = merge_prev ? hdr_link_q : hdr_q;
				size_wd = merge_prev ? (size_rd_q + hdr_size_q) : size_rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (link_re) begin
			link_rd_q <= link_mem[link_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (size_we) begin
			size_mem[size_wa] <= size_wd;
		end
		if (size_re) begin
			size_rd_q <= size_mem[size_ra];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_q      <= ALIGN_W'(HEADER_BYTES);
			heap_bytes_q <= HEAP_W'(HEAP_MAX_BYTES);
			heap_len_q   <= HEAP_W'(HEAP_MAX_BYTES);
			clr_idx_q    <= '0;
		end else begin
			if (cfg_wr_en && (cfg_index == CFG_ALIGN)) begin
				align_q <= cfg_data[ALIGN_W-1:0];
			end
			if (cfg_wr_en && (cfg_index == CFG_HEAP)) begin
				heap_bytes_q <= cfg_data[HEAP_W-1:0];
			end
			if (cmd.op == OP_LOAD && req_type == REQ_INIT) begin
				heap_len_q <= hlen_d;
				clr_idx_q  <= '0;
			end else if (cmd.op == OP_CLEAR) begin
				clr_idx_q <= clr_idx_q + SLOT_W'(1);
			end
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				type_q    <= req_type;
				need_q    <= need_d;
				free_ok_q <= free_ok_d;
				hdr_q     <= VAL_W'(hdr16);
				prev_q    <= '0;
				steps_q   <= '0;
			end
			OP_A_CUR: cur_q <= link_rd_q;
			OP_A_ADV: begin
				prev_q  <= cur_q;
				steps_q <= steps_q + STEP_W'(1);
			end
			OP_F_STEP: begin
				nxt_q <= link_rd_q;
				if (!stat.f_stop) begin
					prev_q  <= link_rd_q;
					steps_q <= steps_q + STEP_W'(1);
				end
			end
			OP_F_R2: begin
				sz_hdr_q  <= size_rd_q;
				lnk_nxt_q <= link_rd_q;
			end
			OP_F_W1: begin
				hdr_link_q <= link_wd;
				hdr_size_q <= size_wd;
			end
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			granted      <= cmd.res_ok;
			block_offset <= (cmd.res_ok && type_q == REQ_ALLOC)
				? OFF_W'(cur_q + VAL_W'(HEADER_BYTES)) : '0;
		end
	end

	assign stat.req_type  = type_q;
	assign stat.free_ok   = free_ok_q;
	assign stat.cur_zero  = (link_rd_q == '0);
	assign stat.fits      = (NEED_W'(size_rd_q) >= need_q);
	assign stat.exact     = (NEED_W'(size_rd_q) == need_q);
	assign stat.f_stop    = (link_rd_q == '0) || (link_rd_q >= hdr_q);
	assign stat.step_last = (steps_q == STEP_W'(STORE_DEPTH));
	assign stat.clr_last  = (clr_idx_q == SLOT_W'(STORE_DEPTH - 1));

endmodule

// ===== sv/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit allocator over an address-ordered free list with coalescing
// ----------------------------------------------------------------------------
// One request at a time, one result transaction per request. The header
// stores hold 8192 entries each and are walked one free-list header at a
// time through a single read port per store, so the cost depends on how
// fragmented the heap is: allocate grows with the free blocks visited, free
// with the free blocks below the freed address, while an unknown type or a
// rejected free goes straight to the result. Init sweeps both stores one
// entry a cycle. After reset the same sweep runs before the first request
// is taken; register writes are taken throughout. A new request is taken
// while an earlier result still waits at the output.
module first_fit_heap_allocator
	import ffha_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// register writes
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            req_type,
	input  logic [OFF_W-1:0]      alloc_size,
	input  logic [OFF_W-1:0]      free_offset,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [OFF_W-1:0]      block_offset,
	output logic                  granted
);

	ffha_cmd_t  cmd;
	ffha_stat_t stat;

	// sequencer
	ffha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// stores and walk registers
	ffha_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_type     (req_type),
		.alloc_size   (alloc_size),
		.free_offset  (free_offset),
		.cmd          (cmd),
		.stat         (stat),
		.block_offset (block_offset),
		.granted      (granted)
	);

	// a granted block always sits on a header boundary
	a_offset_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && block_offset != '0) |-> (block_offset[2:0] == 3'd0))
		else $error("granted offset not header aligned");

	// a nonzero offset only comes with a grant
	a_offset_granted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && block_offset != '0) |-> granted)
		else $error("offset returned without grant");

	// an accepted request keeps the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request channel open right after accept");

endmodule
